// ===== hdl/whpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whpg_pkg
// Shared constants, arctangent table and helpers of the hue palette generator.
// ----------------------------------------------------------------------------
package whpg_pkg;

	localparam int IDX_W  = 16;
	localparam int FRAC_W = 16;
	localparam int STEPS  = 18;
	localparam int CW     = 52;
	localparam int ZW     = 33;
	localparam int NW     = 36;
	localparam int DW     = 18;
	localparam int HW     = 40;
	localparam int NST    = STEPS + NW + 8;

	localparam logic [2:0] REG_COUNT     = 3'd0;
	localparam logic [2:0] REG_MODE      = 3'd1;
	localparam logic [2:0] REG_START     = 3'd2;
	localparam logic [2:0] REG_SPAN      = 3'd3;
	localparam logic [2:0] REG_IN_SCALE  = 3'd4;
	localparam logic [2:0] REG_OUT_SCALE = 3'd5;

	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_ATAN   = 2'd1;

	localparam logic [15:0] CHROMA = 16'd32768;

	localparam logic [31:0] ATAN_TAB [0:STEPS-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF
	};

	// Right shift that rounds toward zero for negative values.
	function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
		input int unsigned sh);
		logic signed [CW-1:0] mag;
		begin
			mag = v[CW-1] ? -v : v;
			mag = mag >> sh;
			shr_tz = v[CW-1] ? -mag : mag;
		end
	endfunction

endpackage

// ===== hdl/weighted_hue_palette_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_hue_palette_generator_core
// Maps a palette index to a hue by linear or arctangent spacing, then to RGB.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one palette index per transfer. The master stream
// returns one color per index: red, green and blue in Q1.15 in tdata, and in
// tuser a flag that is set when the index is not below the palette count.
// Registers are written over the cfg channel, which is always ready; they may
// only change while no index is in flight.
// The pipeline is 62 stages deep: 18 for the CORDIC arctangent, 36 for the
// restoring divider, and 8 for input, scaling, sign handling and color.
// A new index is accepted in every cycle unless the receiver stalls, so the
// throughput is one color per cycle. When the receiver stalls, the whole
// pipeline holds and s_axis_tready falls until the waiting result is taken;
// nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: 256 entries,
// linear mode, start 0, span 5.0 sectors, input scale 1.0, output scale 1.5708.
// ----------------------------------------------------------------------------
module weighted_hue_palette_generator_core
	import whpg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IDX_W-1:0]   s_axis_tdata,   // palette_index
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [47:0]        m_axis_tdata,   // blue, green, red
	output logic               m_axis_tuser,   // index_out_of_range
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [IDX_W-1:0]         count_q;
	logic [1:0]               mode_q;
	logic [FRAC_W+2:0]        start_q;
	logic signed [FRAC_W+3:0] span_q;
	logic [31:0]              in_scale_q;
	logic [FRAC_W+1:0]        out_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 16'd256;
			mode_q      <= MODE_LINEAR;
			start_q     <= '0;
			span_q      <= 20'sd327680;
			in_scale_q  <= 32'd16777216;
			out_scale_q <= 18'd102944;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COUNT:     count_q     <= cfg_data[IDX_W-1:0];
				REG_MODE:      mode_q      <= cfg_data[1:0];
				REG_START:     start_q     <= cfg_data[FRAC_W+2:0];
				REG_SPAN:      span_q      <= cfg_data[FRAC_W+3:0];
				REG_IN_SCALE:  in_scale_q  <= cfg_data;
				REG_OUT_SCALE: out_scale_q <= cfg_data[FRAC_W+1:0];
				default: ;
			endcase
		end
	end

	logic linear, mirror;
	logic [DW-1:0] div_d;

	assign linear = (mode_q == MODE_LINEAR);
	assign mirror = (mode_q != MODE_LINEAR) && (mode_q != MODE_ATAN);

	always_comb begin
		if (linear)
			div_d = (count_q == '0) ? 18'd2 : {1'b0, count_q, 1'b0};
		else
			div_d = (out_scale_q == '0) ? 18'd1 : out_scale_q;
	end

	logic en;
	logic [NST-1:0] vld_q;
	logic [NST-1:0] flg_q;

	assign en            = !vld_q[NST-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NST-1];
	assign m_axis_tuser  = flg_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_q <= {flg_q[NST-2:0], (s_axis_tdata >= count_q)};
		end
	end

	// Input stage: index center and arctangent operand.
	logic [IDX_W:0]        t_in;
	logic signed [IDX_W+1:0] d_in;
	logic [IDX_W:0]        t_s1, op_s1;
	logic                  dneg_s1;

	assign t_in = {s_axis_tdata, 1'b1};
	assign d_in = $signed({1'b0, count_q, 1'b0}) - $signed({1'b0, t_in});

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_in;
			if (mirror) begin
				op_s1   <= d_in[IDX_W+1] ? -d_in[IDX_W:0] : d_in[IDX_W:0];
				dneg_s1 <= d_in[IDX_W+1];
			end else begin
				op_s1   <= t_in;
				dneg_s1 <= 1'b0;
			end
		end
	end

	logic [48:0]    m_s2;
	logic [IDX_W:0] t_s2;
	logic           dneg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= op_s1 * in_scale_q;
			t_s2    <= t_s1;
			dneg_s2 <= dneg_s1;
		end
	end

	// CORDIC vectoring, one iteration per stage.
	logic signed [CW-1:0] cx_s [STEPS];
	logic signed [CW-1:0] cy_s [STEPS];
	logic signed [ZW-1:0] cz_s [STEPS];
	logic [IDX_W:0]       ct_s [STEPS];
	logic                 cneg_s [STEPS];

	genvar gi;
	generate
		for (gi = 0; gi < STEPS; gi++) begin : g_cordic
			logic signed [CW-1:0] xi, yi, dx, dy;
			logic signed [ZW-1:0] zi, ang;
			logic [IDX_W:0]       ti;
			logic                 ni;

			if (gi == 0) begin : g_first
				assign xi = CW'(64'sd33554432);
				assign yi = {{(CW-49){1'b0}}, m_s2};
				assign zi = '0;
				assign ti = t_s2;
				assign ni = dneg_s2;
			end else begin : g_next
				assign xi = cx_s[gi-1];
				assign yi = cy_s[gi-1];
				assign zi = cz_s[gi-1];
				assign ti = ct_s[gi-1];
				assign ni = cneg_s[gi-1];
			end

			assign dx  = shr_tz(yi, gi);
			assign dy  = shr_tz(xi, gi);
			assign ang = {1'b0, ATAN_TAB[gi]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (yi > 0) begin
						cx_s[gi] <= xi + dx;
						cy_s[gi] <= yi - dy;
						cz_s[gi] <= zi + ang;
					end else begin
						cx_s[gi] <= xi - dx;
						cy_s[gi] <= yi + dy;
						cz_s[gi] <= zi - ang;
					end
					ct_s[gi]   <= ti;
					cneg_s[gi] <= ni;
				end
			end
		end
	endgenerate

	// Round the angle to FRAC_W fraction bits and apply the mirror sign.
	logic [ZW-1:0]    zc, zr;
	logic signed [18:0] a_s3;
	logic [IDX_W:0]   t_s3;

	assign zc = cz_s[STEPS-1][ZW-1] ? '0 : cz_s[STEPS-1];
	assign zr = zc + ZW'(33'd8192);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= cneg_s[STEPS-1] ? -$signed({1'b0, zr[31:14]})
				: $signed({1'b0, zr[31:14]});
			t_s3 <= ct_s[STEPS-1];
		end
	end

	logic signed [38:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (linear)
				prod_s4 <= span_q * $signed({2'b0, t_s3});
			else
				prod_s4 <= span_q * a_s3;
		end
	end

	logic [NW-1:0] num_s5;
	logic          neg_s5;
	logic signed [38:0] prod_abs;

	assign prod_abs = prod_s4[38] ? -prod_s4 : prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= prod_abs[NW-1:0];
			neg_s5 <= prod_s4[38];
		end
	end

	// Restoring divider, one quotient bit per stage.
	logic [DW-1:0] dr_s [NW];
	logic [NW-1:0] dw_s [NW];
	logic          dn_s [NW];

	generate
		for (gi = 0; gi < NW; gi++) begin : g_div
			logic [DW-1:0] ri;
			logic [NW-1:0] wi;
			logic          ni;
			logic [DW:0]   tmp, dif;
			logic          ge;

			if (gi == 0) begin : g_first
				assign ri = '0;
				assign wi = num_s5;
				assign ni = neg_s5;
			end else begin : g_next
				assign ri = dr_s[gi-1];
				assign wi = dw_s[gi-1];
				assign ni = dn_s[gi-1];
			end

			assign tmp = {ri, wi[NW-1]};
			assign dif = tmp - {1'b0, div_d};
			assign ge  = (tmp >= {1'b0, div_d});

			always_ff @(posedge clk) begin
				if (en) begin
					dr_s[gi] <= ge ? dif[DW-1:0] : tmp[DW-1:0];
					dw_s[gi] <= {wi[NW-2:0], ge};
					dn_s[gi] <= ni;
				end
			end
		end
	endgenerate

	logic signed [HW-1:0] q_s6;
	logic [HW-1:0]        q_mag;

	assign q_mag = {{(HW-NW){1'b0}}, dw_s[NW-1]}
		+ HW'((dn_s[NW-1] && (dr_s[NW-1] != '0)) ? 1 : 0);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s6 <= dn_s[NW-1] ? -$signed(q_mag) : $signed(q_mag);
		end
	end

	logic signed [HW-1:0] h_sum;
	logic [FRAC_W+2:0]    h_s7;

	assign h_sum = $signed({{(HW-FRAC_W-3){1'b0}}, start_q})
		+ (mirror ? (HW'(span_q) - q_s6) : q_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			if (h_sum < 0)
				h_s7 <= '0;
			else if (h_sum >= $signed(HW'(6 << FRAC_W)))
				h_s7 <= 19'((6 << FRAC_W) - 1);
			else
				h_s7 <= h_sum[FRAC_W+2:0];
		end
	end

	logic [15:0] f15, xv;
	logic [15:0] red_s8, green_s8, blue_s8;

	assign f15 = {1'b0, h_s7[FRAC_W-1:1]};
	assign xv  = h_s7[FRAC_W] ? CHROMA - f15 : f15;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (h_s7[FRAC_W+2:FRAC_W])
				3'd0: begin red_s8 <= CHROMA; green_s8 <= xv;     blue_s8 <= '0;     end
				3'd1: begin red_s8 <= xv;     green_s8 <= CHROMA; blue_s8 <= '0;     end
				3'd2: begin red_s8 <= '0;     green_s8 <= CHROMA; blue_s8 <= xv;     end
				3'd3: begin red_s8 <= '0;     green_s8 <= xv;     blue_s8 <= CHROMA; end
				3'd4: begin red_s8 <= xv;     green_s8 <= '0;     blue_s8 <= CHROMA; end
				default: begin red_s8 <= CHROMA; green_s8 <= '0;  blue_s8 <= xv;     end
			endcase
		end
	end

	assign m_axis_tdata = {blue_s8, green_s8, red_s8};

endmodule
